// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the pose transform RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied.
`define QPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define QPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/qpt_pkg.sv
// Types and constants for the quaternion pose transform.
// No dependencies; used by every module of the block.
`default_nettype none

package qpt_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned FracQ  = 14;
  localparam int unsigned TW     = 36;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SumW   = 42;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [QuatW-1:0]  qcomp_t;
  typedef logic signed [TW-1:0]     tcomp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec32_t;

  typedef struct packed {
    tcomp_t x;
    tcomp_t y;
    tcomp_t z;
  } vect_t;

  typedef struct packed {
    qcomp_t x;
    qcomp_t y;
    qcomp_t z;
    qcomp_t w;
  } quat_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUAT_X = 3'd0,
    CFG_QUAT_Y = 3'd1,
    CFG_QUAT_Z = 3'd2,
    CFG_QUAT_W = 3'd3,
    CFG_POS_X  = 3'd4,
    CFG_POS_Y  = 3'd5,
    CFG_POS_Z  = 3'd6
  } cfg_idx_e;

  localparam qcomp_t QuatWReset = 16'sd16384;
  localparam coord_t CoordMax   = 32'sh7fff_ffff;
  localparam coord_t CoordMin   = 32'sh8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/qpt_rot_front.sv
// First half of the rotation: u x v products, then t = 2*(u x v).
// Depends on qpt_pkg.
`default_nettype none

module qpt_rot_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire qpt_pkg::vec32_t v_i,
  input  wire qpt_pkg::quat_t  quat_i,
  output logic                valid_o,
  output qpt_pkg::vec32_t     v_o,
  output qpt_pkg::vect_t      t_o
);
  import qpt_pkg::*;

  localparam int unsigned PW = QuatW + CoordW;
  localparam int unsigned SW = PW - FracQ;

  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic                 valid1_q, valid2_q;
  vec32_t               v1_q, v2_q;
  vect_t                t_d, t_q;
  logic [SW:0]          c_x, c_y, c_z;

  always_comb begin
    p_d[0] = quat_i.y * v_i.z;
    p_d[1] = quat_i.z * v_i.y;
    p_d[2] = quat_i.z * v_i.x;
    p_d[3] = quat_i.x * v_i.z;
    p_d[4] = quat_i.x * v_i.y;
    p_d[5] = quat_i.y * v_i.x;
  end

  // Shift each product on its own, then take the difference.
  always_comb begin
    c_x = {p_q[0][PW-1], p_q[0][PW-1:FracQ]} - {p_q[1][PW-1], p_q[1][PW-1:FracQ]};
    c_y = {p_q[2][PW-1], p_q[2][PW-1:FracQ]} - {p_q[3][PW-1], p_q[3][PW-1:FracQ]};
    c_z = {p_q[4][PW-1], p_q[4][PW-1:FracQ]} - {p_q[5][PW-1], p_q[5][PW-1:FracQ]};
    t_d.x = {c_x, 1'b0};
    t_d.y = {c_y, 1'b0};
    t_d.z = {c_z, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    v1_q <= v_i;
    t_q  <= t_d;
    v2_q <= v1_q;
  end

  assign valid_o = valid2_q;
  assign v_o     = v2_q;
  assign t_o     = t_q;

endmodule

`default_nettype wire

// File: hw/rtl/qpt_rot_back.sv
// Second half: u x t and w*t products, then the sum with v and the
// translation, saturated to 32 bits. Depends on qpt_pkg.
`default_nettype none

module qpt_rot_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire qpt_pkg::vec32_t v_i,
  input  wire qpt_pkg::vect_t  t_i,
  input  wire qpt_pkg::quat_t  quat_i,
  input  wire qpt_pkg::vec32_t pos_i,
  output logic                valid_o,
  output qpt_pkg::vec32_t     out_o
);
  import qpt_pkg::*;

  localparam int unsigned MW = QuatW + TW;
  localparam int unsigned SW = MW - FracQ;

  logic signed [MW-1:0] m_d [9];
  logic signed [MW-1:0] m_q [9];
  logic                 valid3_q, valid4_q;
  vec32_t               v3_q;
  vec32_t               out_d, out_q;
  logic signed [SumW-1:0] s_x, s_y, s_z;

  always_comb begin
    m_d[0] = quat_i.y * t_i.z;
    m_d[1] = quat_i.z * t_i.y;
    m_d[2] = quat_i.z * t_i.x;
    m_d[3] = quat_i.x * t_i.z;
    m_d[4] = quat_i.x * t_i.y;
    m_d[5] = quat_i.y * t_i.x;
    m_d[6] = quat_i.w * t_i.x;
    m_d[7] = quat_i.w * t_i.y;
    m_d[8] = quat_i.w * t_i.z;
  end

  function automatic logic signed [SumW-1:0] shx(input logic signed [MW-1:0] m);
    return {{(SumW-SW){m[MW-1]}}, m[MW-1:FracQ]};
  endfunction

  function automatic logic signed [SumW-1:0] cx(input coord_t a);
    return {{(SumW-CoordW){a[CoordW-1]}}, a};
  endfunction

  function automatic coord_t sat(input logic signed [SumW-1:0] s);
    coord_t r;
    if (s > cx(CoordMax)) r = CoordMax;
    else if (s < cx(CoordMin)) r = CoordMin;
    else r = s[CoordW-1:0];
    return r;
  endfunction

  always_comb begin
    s_x = cx(v3_q.x) + shx(m_q[6]) + shx(m_q[0]) - shx(m_q[1]) + cx(pos_i.x);
    s_y = cx(v3_q.y) + shx(m_q[7]) + shx(m_q[2]) - shx(m_q[3]) + cx(pos_i.y);
    s_z = cx(v3_q.z) + shx(m_q[8]) + shx(m_q[4]) - shx(m_q[5]) + cx(pos_i.z);
    out_d.x = sat(s_x);
    out_d.y = sat(s_y);
    out_d.z = sat(s_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    v3_q  <= v_i;
    out_q <= out_d;
  end

  assign valid_o = valid4_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_pose_transform.sv
// Top level of the quaternion pose transform: pose registers and pipeline.
// Depends on qpt_pkg, qpt_rot_front, qpt_rot_back and assert_macros.svh.
`default_nettype none

// Rotates each vertex by the pose quaternion and adds the pose translation.
// One vertex is taken every clock (busy never rises) and its posed vertex
// appears on out_*_o with done_o after the four register stages: the u x v
// products, t, the u x t and w*t products, and the saturated sum. Results
// are shown for one cycle only and cannot be held off, so collect every
// done_o strobe. Write the pose through the cfg channel (always ready)
// only while no vertex is in flight.
module quaternion_pose_transform (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [31:0]        in_x_i,
  input  wire logic signed [31:0]        in_y_i,
  input  wire logic signed [31:0]        in_z_i,
  output logic                           done_o,
  output logic signed [31:0]             out_x_o,
  output logic signed [31:0]             out_y_o,
  output logic signed [31:0]             out_z_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [qpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qpt_pkg::CfgDataW-1:0] cfg_data_i
);
  import qpt_pkg::*;

  quat_t  quat_q;
  vec32_t pos_q;
  vec32_t v_in;
  vec32_t v_mid;
  vect_t  t_mid;
  logic   valid_mid;
  vec32_t res;
  logic   accept;

  // The pipeline never stalls, so take an item whenever start is high.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign v_in.x = in_x_i;
  assign v_in.y = in_y_i;
  assign v_in.z = in_z_i;

  // Pose registers; drop writes to indexes beyond the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      quat_q.w <= QuatWReset;
      pos_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUAT_X: quat_q.x <= cfg_data_i[QuatW-1:0];
        CFG_QUAT_Y: quat_q.y <= cfg_data_i[QuatW-1:0];
        CFG_QUAT_Z: quat_q.z <= cfg_data_i[QuatW-1:0];
        CFG_QUAT_W: quat_q.w <= cfg_data_i[QuatW-1:0];
        CFG_POS_X:  pos_q.x  <= cfg_data_i[CoordW-1:0];
        CFG_POS_Y:  pos_q.y  <= cfg_data_i[CoordW-1:0];
        CFG_POS_Z:  pos_q.z  <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Stages one and two: u x v products, then t = 2*(u x v).
  qpt_rot_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .v_i     (v_in),
    .quat_i  (quat_q),
    .valid_o (valid_mid),
    .v_o     (v_mid),
    .t_o     (t_mid)
  );

  // Stages three and four: u x t and w*t, then sum, translate, saturate.
  qpt_rot_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_mid),
    .v_i     (v_mid),
    .t_i     (t_mid),
    .quat_i  (quat_q),
    .pos_i   (pos_q),
    .valid_o (done_o),
    .out_o   (res)
  );

  assign out_x_o = res.x;
  assign out_y_o = res.y;
  assign out_z_o = res.z;

`include "assert_macros.svh"

  // Every accepted item comes out with a done_o strobe.
  `QPT_ASSERT(a_latency, accept |-> ##4 done_o, "accepted item did not emerge after four cycles")
  // No result without an accepted item behind it.
  `QPT_ASSERT(a_no_phantom, done_o |-> $past(accept, 4), "result strobe without accepted item")
  // The mid-pipeline valid passes through valid3_q and valid4_q to the strobe.
  `QPT_ASSERT(a_mid_valid, valid_mid |=> ##1 done_o, "item lost between pipeline halves")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for quaternion_pose_transform: streams vertices, predicts each
// posed vertex from its own copy of the pose and compares every done_o strobe.
// Depends on qpt_pkg and the quaternion_pose_transform RTL only.
`timescale 1ns / 100ps

module testbench;
  import qpt_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomPoses = 9;
  localparam int unsigned VerticesPerPose = 50;
  // Index 7 fits the index port but names no register; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  coord_t              in_x_i;
  coord_t              in_y_i;
  coord_t              in_z_i;
  logic                done_o;
  coord_t              out_x_o;
  coord_t              out_y_o;
  coord_t              out_z_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  quaternion_pose_transform i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns period: 10 ns low, 10 ns high.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Vertices waiting to be driven, and posed vertices waiting for their strobe.
  vec32_t pending_vertices[$];
  vec32_t posed_expected[$];

  // Our own copy of the pose registers, updated at each accepted cfg write.
  longint pose_ux, pose_uy, pose_uz, pose_w;
  longint pose_px, pose_py, pose_pz;

  int unsigned mismatch_count;
  int unsigned stall_cycles;
  bit          item_taken;     // set at the edge that accepts an item, cleared by the driver
  bit          steady_stream;  // suppress random idling on the vertex side

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Q1.14 times wide value, then floor-shift by 14 (>>> on a signed longint floors).
  function automatic longint scale_q14(input longint q, input longint a);
    return (q * a) >>> 14;
  endfunction

  // One component of a scaled cross product: each product is shifted on its own.
  function automatic longint cross_term(input longint p, input longint a,
                                        input longint q, input longint b);
    return scale_q14(p, a) - scale_q14(q, b);
  endfunction

  function automatic coord_t clamp_coord(input longint s);
    if (s > longint'(CoordMax)) return CoordMax;
    if (s < longint'(CoordMin)) return CoordMin;
    return coord_t'(s);
  endfunction

  // Posed vertex: t = 2*(u x v), v' = v + w*t + u x t, then add the translation.
  function automatic vec32_t pose_vertex(input vec32_t v);
    longint vx, vy, vz, tx, ty, tz, rx, ry, rz;
    vec32_t p;
    vx = longint'($signed(v.x));
    vy = longint'($signed(v.y));
    vz = longint'($signed(v.z));
    tx = 2 * cross_term(pose_uy, vz, pose_uz, vy);
    ty = 2 * cross_term(pose_uz, vx, pose_ux, vz);
    tz = 2 * cross_term(pose_ux, vy, pose_uy, vx);
    rx = vx + scale_q14(pose_w, tx) + cross_term(pose_uy, tz, pose_uz, ty) + pose_px;
    ry = vy + scale_q14(pose_w, ty) + cross_term(pose_uz, tx, pose_ux, tz) + pose_py;
    rz = vz + scale_q14(pose_w, tz) + cross_term(pose_ux, ty, pose_uy, tx) + pose_pz;
    p.x = clamp_coord(rx);
    p.y = clamp_coord(ry);
    p.z = clamp_coord(rz);
    return p;
  endfunction

  // Driver: present a new item at the falling edge once the previous one has
  // been taken (or nothing is presented); otherwise hold the current item.
  always @(negedge clk_i) begin
    vec32_t next_vertex;
    if (rst_ni && (!start || item_taken)) begin
      item_taken = 1'b0;
      if (pending_vertices.size() != 0 && (steady_stream || $urandom_range(99) >= 10)) begin
        next_vertex = pending_vertices.pop_front();
        start  <= 1'b1;
        in_x_i <= next_vertex.x;
        in_y_i <= next_vertex.y;
        in_z_i <= next_vertex.z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check any result first, then record an accepted item or a pose write.
  always @(posedge clk_i) begin
    vec32_t want;
    vec32_t taken;
    if (rst_ni) begin
      if (done_o) begin
        if (posed_expected.size() == 0) begin
          report_mismatch($sformatf("result (%h %h %h) with no vertex outstanding",
                                    out_x_o, out_y_o, out_z_o));
        end else begin
          want = posed_expected.pop_front();
          if (out_x_o !== want.x)
            report_mismatch($sformatf("out_x got %h want %h", out_x_o, want.x));
          if (out_y_o !== want.y)
            report_mismatch($sformatf("out_y got %h want %h", out_y_o, want.y));
          if (out_z_o !== want.z)
            report_mismatch($sformatf("out_z got %h want %h", out_z_o, want.z));
        end
      end
      if (start && !busy) begin
        taken.x = in_x_i;
        taken.y = in_y_i;
        taken.z = in_z_i;
        posed_expected = {posed_expected, pose_vertex(taken)};
        item_taken = 1'b1;
      end
      // Quaternion registers keep the low 16 bits; an unused index is dropped.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_QUAT_X: pose_ux = longint'($signed(cfg_data_i[QuatW-1:0]));
          CFG_QUAT_Y: pose_uy = longint'($signed(cfg_data_i[QuatW-1:0]));
          CFG_QUAT_Z: pose_uz = longint'($signed(cfg_data_i[QuatW-1:0]));
          CFG_QUAT_W: pose_w  = longint'($signed(cfg_data_i[QuatW-1:0]));
          CFG_POS_X:  pose_px = longint'($signed(cfg_data_i));
          CFG_POS_Y:  pose_py = longint'($signed(cfg_data_i));
          CFG_POS_Z:  pose_pz = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
    end
  end

  // Watchdog: end the run if no item, result or pose write is seen for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("** quaternion_pose_transform: FAILED **");
          $finish;
        end
      end
    end
  end

  // Write one register; occasionally idle before the write.
  task automatic write_pose_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    if ($urandom_range(99) < 10) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Quaternion word with random junk above the 16 bits that count.
  function automatic logic [CfgDataW-1:0] quat_word(input int v);
    return {16'($urandom()), 16'(v)};
  endfunction

  task automatic set_pose(input int qx, input int qy, input int qz, input int qw,
                          input int px, input int py, input int pz);
    write_pose_reg(CFG_QUAT_X, quat_word(qx));
    write_pose_reg(CFG_QUAT_Y, quat_word(qy));
    write_pose_reg(CFG_QUAT_Z, quat_word(qz));
    write_pose_reg(CFG_QUAT_W, quat_word(qw));
    write_pose_reg(CFG_POS_X, 32'(px));
    write_pose_reg(CFG_POS_Y, 32'(py));
    write_pose_reg(CFG_POS_Z, 32'(pz));
  endtask

  task automatic queue_vertex(input int x, input int y, input int z);
    vec32_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vertices = {pending_vertices, v};
  endtask

  // Wait until every item has been driven and every posed vertex has come back.
  task automatic drain_pipeline();
    while (pending_vertices.size() != 0 || start || posed_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // Uniform value in [-r, r].
  function automatic int spread(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic int random_coord();
    case ($urandom_range(9))
      0, 1:    return int'($urandom());
      2:       return $urandom_range(1) ? int'(CoordMax) : int'(CoordMin);
      default: return spread(1 << 22);
    endcase
  endfunction

  localparam int Max32 = 32'h7fff_ffff;
  localparam int Min32 = 32'h8000_0000;
  localparam int One   = 65536;      // 1.0 in Q16.16
  localparam int QOne  = 16384;      // 1.0 in Q1.14
  localparam int QHalf = 11585;      // about sqrt(0.5) in Q1.14

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    in_x_i        = '0;
    in_y_i        = '0;
    in_z_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    item_taken    = 1'b0;
    steady_stream = 1'b0;
    mismatch_count = 0;
    stall_cycles  = 0;
    // Reset pose is the identity rotation with no translation.
    pose_ux = 0;
    pose_uy = 0;
    pose_uz = 0;
    pose_w  = QOne;
    pose_px = 0;
    pose_py = 0;
    pose_pz = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset pose: vertices should pass through untouched, extremes included.
    queue_vertex(0, 0, 0);
    queue_vertex(Max32, Max32, Max32);
    queue_vertex(Min32, Min32, Min32);
    queue_vertex(Max32, Min32, 1);
    queue_vertex(-1, -1, -1);
    drain_pipeline();

    // Quarter turn about z with a small translation.
    set_pose(0, 0, QHalf, QHalf, One, 2 * One, -3 * One);
    queue_vertex(One, 0, 0);
    queue_vertex(0, One, 0);
    queue_vertex(0, 0, One);
    queue_vertex(-One, 2 * One, 7);
    drain_pipeline();

    // Most negative components with the largest translation: drive saturation high.
    set_pose(-32768, -32768, -32768, -32768, Max32, Max32, Max32);
    queue_vertex(Min32, Min32, Min32);
    queue_vertex(Max32, Max32, Max32);
    queue_vertex(1, -1, 0);
    drain_pipeline();

    // Largest positive components with the most negative translation.
    set_pose(32767, 32767, 32767, 32767, Min32, Min32, Min32);
    queue_vertex(Min32, Min32, Min32);
    queue_vertex(Max32, Max32, Max32);
    queue_vertex(1, -1, 0);
    drain_pipeline();

    // Non-unit quaternion scales the vertex; a write to the unused index is dropped.
    set_pose(0, 8192, 0, 8192, -One, 0, One);
    write_pose_reg(CfgIdxUnused, $urandom());
    queue_vertex(3 * One, -5 * One, One / 2);
    queue_vertex(Max32, 12345, Min32);
    drain_pipeline();

    // Random poses, each followed by a burst of vertices; one burst runs without gaps.
    for (int p = 0; p < RandomPoses; p++) begin
      if (p % 3 == 0) begin
        set_pose(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                 int'($urandom()), int'($urandom()), int'($urandom()));
      end else begin
        set_pose(spread(QOne), spread(QOne), spread(QOne), spread(QOne),
                 spread(1 << 24), spread(1 << 24), spread(1 << 24));
      end
      if ($urandom_range(3) == 0) write_pose_reg(CfgIdxUnused, $urandom());
      steady_stream = (p == 4);
      for (int n = 0; n < VerticesPerPose; n++)
        queue_vertex(random_coord(), random_coord(), random_coord());
      drain_pipeline();
    end
    steady_stream = 1'b0;

    // Let any stray strobe show itself before the verdict.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** quaternion_pose_transform: PASSED **");
    end else begin
      $display("** quaternion_pose_transform: FAILED **");
    end
    $finish;
  end

endmodule
